### hdl/ellipse_closest_point_search_core_assert.svh
// Assertion macros shared by the ellipse closest-point search RTL.
// The macros expect a signal named clk, and ECPS_ASSERT also one named rst, in the module that uses them.
`ifndef ELLIPSE_CLOSEST_POINT_SEARCH_CORE_ASSERT_SVH
`define ELLIPSE_CLOSEST_POINT_SEARCH_CORE_ASSERT_SVH

// Clocked check, switched off while reset is high
`define ECPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Clocked check that also holds through reset
`define ECPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

### hdl/ecps_pkg.sv
// Shared constants, types and sine table builder for the ellipse search.
// No dependencies; imported by every module of the block.
package ecps_pkg;

  // Angle sampling
  localparam int STEPS_LOG = 16;
  localparam int STEPS     = 1 << STEPS_LOG;
  localparam int QUARTER   = STEPS / 4;
  localparam int QBITS     = STEPS_LOG - 2;
  localparam int ADDR_W    = QBITS + 1;

  // Data widths
  localparam int SINE_W      = 18;
  localparam int AXIS_W      = 31;
  localparam int COORD_W     = 32;
  localparam int PROD_W      = AXIS_W + SINE_W;
  localparam int ROUND_SHIFT = PROD_W - COORD_W;
  localparam int SQ_W        = 2 * COORD_W;
  localparam int DIST_W      = SQ_W + 1;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [PROD_W-1:0]   ROUND_HALF = PROD_W'(1) << (ROUND_SHIFT - 1);
  localparam logic [AXIS_W-1:0]   AXIS_RESET = AXIS_W'(65536);
  localparam logic [STEPS_LOG-1:0] CNT_LAST  = STEPS_LOG'(STEPS - 1);

  // Table generation constants
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned SINE_ONE    = 64'd131072;

  // Register indexes (byte address bit 2)
  typedef enum logic {
    REG_AXIS_X = 1'b0,
    REG_AXIS_Y = 1'b1
  } ecps_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } ecps_state_t;

  // Per-sample control that rides along the pipeline
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } ecps_tag_t;

  // Status from the minimum tracker back to the controller
  typedef struct packed {
    logic advance;
    logic done;
  } ecps_ctrl_t;

  typedef logic [SINE_W-1:0] sine_rom_t [QUARTER+1];

  // One quarter-wave entry: Taylor series in Q2.30, rounded to Q1.17
  function automatic logic [SINE_W-1:0] quarter_sine(input longint unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned v;
    longint          sum;
    x    = (k * HALF_PI_Q30) / QUARTER;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 6;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 20;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 42;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 72;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 110;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 156;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 210;
    sum  = sum - $signed(term);
    if (sum < 0) begin
      sum = 0;
    end
    v = ($unsigned(sum) + 64'd4096) >> 13;
    if (v > SINE_ONE) begin
      v = SINE_ONE;
    end
    return v[SINE_W-1:0];
  endfunction

endpackage

### hdl/ecps_sine_rom.sv
// Quarter-wave sine ROM with two registered read ports.
// Depends on ecps_pkg for the table contents and widths.
module ecps_sine_rom (
  input  logic                        clk,
  input  logic                        en,
  input  logic [ecps_pkg::ADDR_W-1:0] addr_a,
  input  logic [ecps_pkg::ADDR_W-1:0] addr_b,
  output logic [ecps_pkg::SINE_W-1:0] data_a,
  output logic [ecps_pkg::SINE_W-1:0] data_b
);
  import ecps_pkg::*;

  sine_rom_t sine_rom;

  // Table contents, filled once at time zero
  initial begin
    for (int k = 0; k <= QUARTER; k++) begin
      sine_rom[k] = quarter_sine(64'(k));
    end
  end

  // Both ports read every advancing cycle
  always_ff @(posedge clk) begin
    if (en) begin
      data_a <= sine_rom[addr_a];
      data_b <= sine_rom[addr_b];
    end
  end

endmodule

### hdl/ecps_point_dist.sv
// Pipeline from sine magnitudes to ellipse point and squared distance.
// Stages: product, rounded point, abs difference, squares, sum. Uses ecps_pkg.
module ecps_point_dist (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  ecps_pkg::ecps_tag_t                 tag_in,
  input  logic [ecps_pkg::SINE_W-1:0]         sin_mag,
  input  logic [ecps_pkg::SINE_W-1:0]         cos_mag,
  input  logic                                sin_neg,
  input  logic                                cos_neg,
  input  logic [ecps_pkg::AXIS_W-1:0]         axis_x,
  input  logic [ecps_pkg::AXIS_W-1:0]         axis_y,
  input  logic signed [ecps_pkg::COORD_W-1:0] query_x,
  input  logic signed [ecps_pkg::COORD_W-1:0] query_y,
  output ecps_pkg::ecps_tag_t                 tag_out,
  output logic [ecps_pkg::DIST_W-1:0]         dist_sq,
  output logic signed [ecps_pkg::COORD_W-1:0] pt_x,
  output logic signed [ecps_pkg::COORD_W-1:0] pt_y
);
  import ecps_pkg::*;

  ecps_tag_t tag2, tag3, tag4, tag5, tag6;

  logic [PROD_W-1:0]         prod_x, prod_y;
  logic                      neg_x2, neg_y2;
  logic signed [COORD_W-1:0] ex3, ey3, ex4, ey4, ex5, ey5, ex6, ey6;
  logic [COORD_W-1:0]        adx4, ady4;
  logic [SQ_W-1:0]           sqx5, sqy5;
  logic [DIST_W-1:0]         dist6;

  logic [PROD_W-1:0]         rnd_x, rnd_y;
  logic [COORD_W-1:0]        mag_x, mag_y;
  logic signed [COORD_W:0]   diff_x, diff_y;

  // Valid bits and markers per stage
  always_ff @(posedge clk) begin
    if (rst) begin
      tag2 <= '0;
      tag3 <= '0;
      tag4 <= '0;
      tag5 <= '0;
      tag6 <= '0;
    end else if (en) begin
      tag2 <= tag_in;
      tag3 <= tag2;
      tag4 <= tag3;
      tag5 <= tag4;
      tag6 <= tag5;
    end
  end

  // Rounding of the Q15.33 product to Q15.16
  assign rnd_x = prod_x + ROUND_HALF;
  assign rnd_y = prod_y + ROUND_HALF;
  assign mag_x = rnd_x[PROD_W-1:ROUND_SHIFT];
  assign mag_y = rnd_y[PROD_W-1:ROUND_SHIFT];

  // Exact differences to the query, one sign bit wider
  assign diff_x = {ex3[COORD_W-1], ex3} - {query_x[COORD_W-1], query_x};
  assign diff_y = {ey3[COORD_W-1], ey3} - {query_y[COORD_W-1], query_y};

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 2: axis times sine magnitude
      prod_x <= PROD_W'(axis_x) * PROD_W'(cos_mag);
      prod_y <= PROD_W'(axis_y) * PROD_W'(sin_mag);
      neg_x2 <= cos_neg;
      neg_y2 <= sin_neg;
      // stage 3: signed ellipse point
      ex3 <= neg_x2 ? -$signed(mag_x) : $signed(mag_x);
      ey3 <= neg_y2 ? -$signed(mag_y) : $signed(mag_y);
      // stage 4: absolute differences fit 32 unsigned bits
      adx4 <= diff_x[COORD_W] ? COORD_W'(-diff_x) : diff_x[COORD_W-1:0];
      ady4 <= diff_y[COORD_W] ? COORD_W'(-diff_y) : diff_y[COORD_W-1:0];
      ex4  <= ex3;
      ey4  <= ey3;
      // stage 5: squares
      sqx5 <= SQ_W'(adx4) * SQ_W'(adx4);
      sqy5 <= SQ_W'(ady4) * SQ_W'(ady4);
      ex5  <= ex4;
      ey5  <= ey4;
      // stage 6: 65-bit distance
      dist6 <= {1'b0, sqx5} + {1'b0, sqy5};
      ex6   <= ex5;
      ey6   <= ey5;
    end
  end

  assign tag_out = tag6;
  assign dist_sq = dist6;
  assign pt_x    = ex6;
  assign pt_y    = ey6;

endmodule

### hdl/ecps_min_select.sv
// Running minimum over the samples of one query, and the result register.
// Depends on ecps_pkg; drives the pipeline advance and done status.
`include "ellipse_closest_point_search_core_assert.svh"

module ecps_min_select (
  input  logic                                clk,
  input  logic                                rst,
  input  ecps_pkg::ecps_tag_t                 tag,
  input  logic [ecps_pkg::DIST_W-1:0]         dist_sq,
  input  logic signed [ecps_pkg::COORD_W-1:0] pt_x,
  input  logic signed [ecps_pkg::COORD_W-1:0] pt_y,
  input  logic                                m_tready,
  output logic                                m_tvalid,
  output logic [2*ecps_pkg::COORD_W-1:0]      m_tdata,
  output ecps_pkg::ecps_ctrl_t                ctrl
);
  import ecps_pkg::*;

  logic [DIST_W-1:0]         best_d;
  logic signed [COORD_W-1:0] best_x, best_y;
  logic                      take;
  logic                      stall;
  logic signed [COORD_W-1:0] win_x, win_y;

  // Hold the pipeline only when the final sample finds the result slot full
  assign stall        = tag.valid && tag.last && m_tvalid && !m_tready;
  assign ctrl.advance = !stall;
  assign ctrl.done    = !stall && tag.valid && tag.last;

  // Strict compare keeps the earliest minimum
  assign take  = tag.first || (dist_sq < best_d);
  assign win_x = take ? pt_x : best_x;
  assign win_y = take ? pt_y : best_y;

  always_ff @(posedge clk) begin
    if (ctrl.advance && tag.valid && take) begin
      best_d <= dist_sq;
      best_x <= pt_x;
      best_y <= pt_y;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.done) begin
      m_tdata <= {win_y, win_x};
    end
  end

  `ECPS_ASSERT(a_first_seeds, (tag.valid && tag.first && ctrl.advance) |=> (best_d == $past(dist_sq)), "first sample did not seed the minimum")
  `ECPS_ASSERT(a_result_is_best, ctrl.done |=> (m_tvalid && m_tdata[COORD_W-1:0] == best_x), "result differs from tracked minimum")

endmodule

### hdl/ellipse_closest_point_search_core.sv
// Top level of the ellipse closest-point search: APB registers, sample
// sequencer and the pipeline. Depends on ecps_pkg and the ecps_* modules.
//
//  channel   direction  beat contents
//  s_*       in         query point, one beat per search
//  m_*       out        nearest sampled ellipse point, one beat per query
//  APB       in/out     semi_axis_x at 0x0, semi_axis_y at 0x4
//
// A query's result becomes valid once all its samples have passed: one angle
// sample per cycle leaves the sine ROM's two read ports, then six pipeline
// stages drain. The next query can be taken once the previous one's final sample
// is done, while its result may still wait in the output register.
// rst is synchronous and returns both semi-axes to 1.0. A stalled m_tready
// freezes the pipeline only when the final sample needs the output register.
`include "ellipse_closest_point_search_core_assert.svh"

module ellipse_closest_point_search_core (
  input  logic                         clk,
  input  logic                         rst,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ecps_pkg::PADDR_W-1:0] paddr,
  input  logic [ecps_pkg::PDATA_W-1:0] pwdata,
  output logic [ecps_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  // query input
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [63:0]                  s_tdata,   // [31:0] query_x, [63:32] query_y
  // result output
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [63:0]                  m_tdata    // [31:0] nearest_x, [63:32] nearest_y
);
  import ecps_pkg::*;

  logic [AXIS_W-1:0]         axis_x, axis_y;
  logic signed [COORD_W-1:0] query_x, query_y;
  ecps_state_t               state, state_next;
  logic [STEPS_LOG-1:0]      cnt;
  logic                      issue;
  ecps_tag_t                 tag1, tag6;
  logic                      sin_neg1, cos_neg1;
  ecps_ctrl_t                ctrl;
  ecps_reg_t                 reg_sel;
  logic                      cfg_write;

  logic [1:0]         quad_s, quad_c;
  logic [QBITS-1:0]   rem;
  logic [ADDR_W-1:0]  addr_s, addr_c;
  logic [SINE_W-1:0]  sin_mag, cos_mag;
  logic [DIST_W-1:0]  dist6;
  logic signed [COORD_W-1:0] pt_x6, pt_y6;

  // APB register file
  assign pready    = 1'b1;
  assign reg_sel   = ecps_reg_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_x <= AXIS_RESET;
      axis_y <= AXIS_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_AXIS_X: axis_x <= pwdata[AXIS_W-1:0];
        REG_AXIS_Y: axis_y <= pwdata[AXIS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_AXIS_X: prdata = {1'b0, axis_x};
      REG_AXIS_Y: prdata = {1'b0, axis_y};
      default:    prdata = '0;
    endcase
  end

  // Sequencer: next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (s_tvalid) state_next = ST_RUN;
      ST_RUN:   if (ctrl.advance && cnt == CNT_LAST) state_next = ST_DRAIN;
      ST_DRAIN: if (ctrl.done) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    s_tready = 1'b0;
    issue    = 1'b0;
    unique case (state)
      ST_IDLE:  s_tready = 1'b1;
      ST_RUN:   issue    = 1'b1;
      ST_DRAIN: ;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Angle counter and query capture
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (s_tvalid && s_tready) begin
      cnt <= '0;
    end else if (issue && ctrl.advance) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      query_x <= s_tdata[COORD_W-1:0];
      query_y <= s_tdata[2*COORD_W-1:COORD_W];
    end
  end

  // Quadrant folding for sine and cosine (cosine is a quarter turn ahead)
  assign quad_s = cnt[STEPS_LOG-1 -: 2];
  assign quad_c = quad_s + 2'd1;
  assign rem    = cnt[QBITS-1:0];
  assign addr_s = quad_s[0] ? (ADDR_W'(QUARTER) - {1'b0, rem}) : {1'b0, rem};
  assign addr_c = quad_c[0] ? (ADDR_W'(QUARTER) - {1'b0, rem}) : {1'b0, rem};

  // Stage 1: ROM read with its tag and signs
  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
    end else if (ctrl.advance) begin
      tag1.valid <= issue;
      tag1.first <= issue && (cnt == '0);
      tag1.last  <= issue && (cnt == CNT_LAST);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      sin_neg1 <= quad_s[1];
      cos_neg1 <= quad_c[1];
    end
  end

  ecps_sine_rom u_rom (
    .clk    (clk),
    .en     (ctrl.advance),
    .addr_a (addr_s),
    .addr_b (addr_c),
    .data_a (sin_mag),
    .data_b (cos_mag)
  );

  ecps_point_dist u_dist (
    .clk     (clk),
    .rst     (rst),
    .en      (ctrl.advance),
    .tag_in  (tag1),
    .sin_mag (sin_mag),
    .cos_mag (cos_mag),
    .sin_neg (sin_neg1),
    .cos_neg (cos_neg1),
    .axis_x  (axis_x),
    .axis_y  (axis_y),
    .query_x (query_x),
    .query_y (query_y),
    .tag_out (tag6),
    .dist_sq (dist6),
    .pt_x    (pt_x6),
    .pt_y    (pt_y6)
  );

  ecps_min_select u_sel (
    .clk      (clk),
    .rst      (rst),
    .tag      (tag6),
    .dist_sq  (dist6),
    .pt_x     (pt_x6),
    .pt_y     (pt_y6),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .ctrl     (ctrl)
  );

  `ECPS_ASSERT(a_idle_drained, s_tready |-> (!tag1.valid && !tag6.valid), "query taken with samples in flight")
  `ECPS_ASSERT(a_count_step, (state == ST_RUN && cnt != CNT_LAST) |=> (state == ST_RUN && cnt == STEPS_LOG'($past(cnt) + 1'b1)), "angle counter skipped or stalled")
  `ECPS_ASSERT(a_done_in_drain, ctrl.done |-> (state == ST_DRAIN), "result finished outside drain")

endmodule

### tb/ellipse_closest_point_search_core_test.sv
`timescale 1ns / 1ps
// Self-checking bench for ellipse_closest_point_search_core: query beats in,
// nearest-point beats out, predicted by an independent exhaustive angle search.
// Depends on ecps_pkg and the block's RTL only.
module ellipse_closest_point_search_core_test;
  import ecps_pkg::*;

  localparam int WATCHDOG_LIMIT = 300000;
  localparam int SETTLE_CYCLES  = 16;

  typedef struct packed {
    logic [31:0] y;
    logic [31:0] x;
  } point_t;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                psel     = 1'b0;
  logic                penable  = 1'b0;
  logic                pwrite   = 1'b0;
  logic [PADDR_W-1:0]  paddr    = '0;
  logic [PDATA_W-1:0]  pwdata   = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [63:0]         s_tdata  = '0;  // [31:0] query_x, [63:32] query_y
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [63:0]         m_tdata;        // [31:0] nearest_x, [63:32] nearest_y

  // Predictor state: semi-axes as last written, quarter-wave sine table
  logic [AXIS_W-1:0] axis_x = AXIS_W'(65536);
  logic [AXIS_W-1:0] axis_y = AXIS_W'(65536);
  logic [17:0]       sine_tab [QUARTER+1];

  logic [63:0] query_q[$];    // query beats waiting for the driver
  point_t      nearest_q[$];  // predicted nearest points, oldest first
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          err_count     = 0;
  int          stall_cycles  = 0;

  ellipse_closest_point_search_core dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    err_count++;
  endtask

  // Taylor series for sin in Q2.30, rounded to Q1.17
  function automatic logic [17:0] taylor_quarter_sine(input longint unsigned k);
    longint unsigned ang, ang_sq, term, val;
    longint          acc;
    ang    = (k * HALF_PI_Q30) / 64'(QUARTER);
    ang_sq = (ang * ang) >> 30;
    term   = ang;
    acc    = longint'(ang);
    for (int n = 1; n <= 7; n++) begin
      term = ((term * ang_sq) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    val = (longint'(acc) + 64'd4096) >> 13;
    if (val > SINE_ONE) val = SINE_ONE;
    return val[17:0];
  endfunction

  // Sine magnitude and sign at angle index idx (full turn = STEPS)
  function automatic logic [17:0] sine_mag(input int unsigned idx, output bit neg);
    int unsigned m, quad, r;
    m    = idx % STEPS;
    quad = m / QUARTER;
    r    = m % QUARTER;
    neg  = (quad >= 2);
    return quad[0] ? sine_tab[QUARTER - r] : sine_tab[r];
  endfunction

  // axis * |sine| rounded half-up from Q15.33 to Q15.16, then signed
  function automatic longint axis_times(input logic [AXIS_W-1:0] axis,
                                        input logic [17:0] mag, input bit neg);
    longint unsigned p;
    p = (64'(axis) * 64'(mag) + 64'd65536) >> 17;
    return neg ? -longint'(p) : longint'(p);
  endfunction

  // Exhaustive search over all sampled angles; first strict minimum wins
  function automatic point_t nearest_point(input logic [31:0] qx_bits,
                                           input logic [31:0] qy_bits);
    longint          qx, qy, ex, ey, dx, dy, best_x, best_y;
    longint unsigned ux, uy;
    logic [64:0]     cur_dist, best_dist;
    logic [17:0]     s, c;
    bit              sneg, cneg;
    point_t          pt;
    qx        = longint'($signed(qx_bits));
    qy        = longint'($signed(qy_bits));
    best_x    = 0;
    best_y    = 0;
    best_dist = '0;
    for (int i = 0; i < STEPS; i++) begin
      s  = sine_mag(i, sneg);
      c  = sine_mag(i + QUARTER, cneg);
      ex = axis_times(axis_x, c, cneg);
      ey = axis_times(axis_y, s, sneg);
      dx = ex - qx;
      dy = ey - qy;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      ux   = dx;
      uy   = dy;
      cur_dist = {1'b0, ux * ux} + {1'b0, uy * uy};
      if (i == 0 || cur_dist < best_dist) begin
        best_dist = cur_dist;
        best_x    = ex;
        best_y    = ey;
      end
    end
    pt.x = best_x[31:0];
    pt.y = best_y[31:0];
    return pt;
  endfunction

  function automatic logic [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // Uniform value in [-lim, lim] around an axis length
  function automatic logic [31:0] near_coord(input logic [AXIS_W-1:0] axis);
    longint lim;
    lim = (longint'(axis) * 5) / 4 + 65536;
    if (lim > 64'sd2147483647) lim = 64'sd2147483647;
    return clamp32(longint'($urandom_range(32'(2 * lim))) - lim);
  endfunction

  // Random query: full-range noise, near the ellipse, small, or close to a sample
  function automatic logic [63:0] random_query();
    logic [31:0] qx, qy;
    logic [17:0] s, c;
    bit          sneg, cneg;
    int unsigned idx;
    case ($urandom_range(3))
      0: begin
        qx = $urandom;
        qy = $urandom;
      end
      1: begin
        qx = near_coord(axis_x);
        qy = near_coord(axis_y);
      end
      2: begin
        qx = clamp32(longint'($urandom_range(32'h0020_0000)) - 64'sh0010_0000);
        qy = clamp32(longint'($urandom_range(32'h0020_0000)) - 64'sh0010_0000);
      end
      default: begin
        idx = $urandom_range(STEPS - 1);
        s   = sine_mag(idx, sneg);
        c   = sine_mag(idx + QUARTER, cneg);
        qx  = clamp32(axis_times(axis_x, c, cneg) + $urandom_range(16) - 8);
        qy  = clamp32(axis_times(axis_y, s, sneg) + $urandom_range(16) - 8);
      end
    endcase
    return {qy, qx};
  endfunction

  function automatic logic [PADDR_W-1:0] reg_addr(input ecps_reg_t r);
    return PADDR_W'({r, 2'b00});
  endfunction

  // APB write: setup then access; the register takes the value on the access edge
  task automatic apb_write(input ecps_reg_t idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= reg_addr(idx);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_AXIS_X) axis_x = value[AXIS_W-1:0];
    else axis_y = value[AXIS_W-1:0];
  endtask

  // APB read, compared with the predictor's copy of the register
  task automatic check_register(input ecps_reg_t idx);
    logic [31:0] want;
    want = (idx == REG_AXIS_X) ? {1'b0, axis_x} : {1'b0, axis_y};
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= reg_addr(idx);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want)
      report_mismatch($sformatf("register %s read %h, expected %h",
                                idx.name(), prdata, want));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_axes(input logic [31:0] vx, input logic [31:0] vy);
    apb_write(REG_AXIS_X, vx);
    apb_write(REG_AXIS_Y, vy);
    check_register(REG_AXIS_X);
    check_register(REG_AXIS_Y);
  endtask

  // Hold off until every query is sent and every result is back
  task automatic wait_drained();
    while (query_q.size() > 0 || s_tvalid || nearest_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_query(input logic [31:0] qx, input logic [31:0] qy);
    query_q.push_back({qy, qx});
  endtask

  // Query driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (query_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata  <= query_q.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result backpressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: predict on each accepted query beat, check each result beat
  always @(posedge clk) begin : monitor
    point_t want;
    if (!rst) begin
      if (s_tvalid && s_tready)
        nearest_q.push_back(nearest_point(s_tdata[31:0], s_tdata[63:32]));
      if (m_tvalid && m_tready) begin
        if (nearest_q.size() == 0) begin
          report_mismatch($sformatf("result beat %h with no query pending", m_tdata));
        end else begin
          want = nearest_q.pop_front();
          if (m_tdata[31:0] !== want.x)
            report_mismatch($sformatf("nearest_x %h, expected %h", m_tdata[31:0], want.x));
          if (m_tdata[63:32] !== want.y)
            report_mismatch($sformatf("nearest_y %h, expected %h",
                                      m_tdata[63:32], want.y));
        end
      end
    end
  end

  // Watchdog on cycles with no beat accepted on either stream
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    for (int k = 0; k <= QUARTER; k++) sine_tab[k] = taylor_quarter_sine(64'(k));
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Unit circle after reset, sender and receiver both idling
    send_idle_pct = 33;
    recv_idle_pct = 48;
    check_register(REG_AXIS_X);
    check_register(REG_AXIS_Y);
    push_query(32'h0000_0000, 32'h0000_0000);  // center: near-ties everywhere
    push_query(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_query(32'h8000_0000, 32'h8000_0000);
    push_query(32'h7FFF_FFFF, 32'h8000_0000);
    push_query(32'h8000_0000, 32'h7FFF_FFFF);
    push_query(32'h0001_0000, 32'h0000_0000);  // exactly on the curve at 0 deg
    push_query(32'h0000_0000, 32'h0001_0000);
    push_query(32'hFFFF_0000, 32'h0000_0000);
    push_query(32'h0000_0000, 32'hFFFF_0000);
    push_query(32'h0002_0000, 32'h0002_0000);
    push_query(32'h5555_5555, 32'hAAAA_AAAA);
    push_query(32'hAAAA_AAAA, 32'h5555_5555);
    push_query(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_drained();

    // Largest axes; the x write sets bit 31, which must be dropped
    set_axes(32'hFFFF_FFFF, 32'h7FFF_FFFF);
    push_query(32'h0000_0000, 32'h0000_0000);
    push_query(32'h7FFF_FFFF, 32'h0000_0000);
    push_query(32'h8000_0000, 32'h8000_0000);
    push_query(32'h0000_0000, 32'h7FFF_FFFF);
    repeat (20) query_q.push_back(random_query());
    wait_drained();

    // Degenerate ellipses: roles of the two sides swapped
    send_idle_pct = 48;
    recv_idle_pct = 33;
    set_axes(32'h0000_0000, 32'h0000_0000);
    push_query(32'h0000_0000, 32'h0000_0000);
    push_query(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_query(32'h8000_0000, 32'h1234_5678);
    wait_drained();
    set_axes(32'h0000_0000, 32'h0003_0000);
    push_query(32'h0001_0000, 32'h0000_0000);
    push_query(32'h0000_0000, 32'h0001_0000);
    wait_drained();

    // Random moderate axes
    set_axes($urandom_range(32'h0040_0000), $urandom_range(32'h0040_0000));
    repeat (30) query_q.push_back(random_query());
    wait_drained();

    // Random full-range axes, no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_axes($urandom, $urandom);
    repeat (27) query_q.push_back(random_query());
    wait_drained();

    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
